// ===== hdl/bslut_pkg.sv =====
// ----------------------------------------------------------------------------
// bslut_pkg - shared definitions for the battery charge lookup
// Field widths, codes and the divider status record used by the interfaces,
// the serial divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bslut_pkg;

   // Breakpoints per table unless the top level is told otherwise
   localparam int DEFAULT_TABLE_DEPTH = 16;

   // Fixed field widths
   localparam int VOLT_W  = 16;
   localparam int PCT_W   = 15;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 5;
   localparam int CODE_W  = 2;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Divider: product of a voltage step and a percent step over a voltage span
   localparam int PROD_W  = VOLT_W + PCT_W;
   localparam int QUO_W   = VOLT_W;

   // Request actions
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Register select (word address bit 2)
   localparam logic REG_DISCHARGE = 1'b0;
   localparam logic REG_CHARGE    = 1'b1;

   // Reset value of both point counts
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

   // How a result was found
   typedef enum logic [CODE_W-1:0] {
      WHERE_INTERP   = 2'd0,
      WHERE_BELOW    = 2'd1,
      WHERE_ABOVE    = 2'd2,
      WHERE_FALLBACK = 2'd3
   } where_type;

   // Divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } bslut_div_status_type;

endpackage

`default_nettype wire

// ===== hdl/bslut_req_if.sv =====
// ----------------------------------------------------------------------------
// bslut_req_if - request channel
// Valid/ready channel carrying one load or query request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bslut_req_if;
   import bslut_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic              charger_connected;
   logic [IDX_W-1:0]  point_index;
   logic [VOLT_W-1:0] point_volt;
   logic [PCT_W-1:0]  point_percent;
   logic [VOLT_W-1:0] query_volt;

   modport source (
      output valid, action, charger_connected, point_index, point_volt,
             point_percent, query_volt,
      input  ready
   );

   modport sink (
      input  valid, action, charger_connected, point_index, point_volt,
             point_percent, query_volt,
      output ready
   );

endinterface

`default_nettype wire

// ===== hdl/bslut_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bslut_rsp_if - result channel
// Valid/ready channel carrying one charge result per query request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bslut_rsp_if;
   import bslut_pkg::*;

   logic              valid;
   logic              ready;
   logic [PCT_W-1:0]  percent;
   logic [CODE_W-1:0] where_found;

   modport source (
      output valid, percent, where_found,
      input  ready
   );

   modport sink (
      input  valid, percent, where_found,
      output ready
   );

endinterface

`default_nettype wire

// ===== hdl/bslut_div.sv =====
// ----------------------------------------------------------------------------
// bslut_div - serial restoring divider
// One quotient bit per cycle. The dividend is known to be below
// divisor * 2^QUO_W, so QUO_W steps give the full quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bslut_div (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire [bslut_pkg::PROD_W-1:0]       dividend,
   input  wire [bslut_pkg::VOLT_W-1:0]       divisor,
   output logic [bslut_pkg::QUO_W-1:0]       quotient,
   output bslut_pkg::bslut_div_status_type   status
);
   import bslut_pkg::*;

   localparam int STEP_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [VOLT_W-1:0] rem_ff, rem_in;
   logic [VOLT_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0]  sreg_ff, sreg_in;

   logic [VOLT_W:0]   trial;
   logic [VOLT_W:0]   diff;

   // Shift the next dividend bit into the remainder and try a subtract
   assign trial = {rem_ff, sreg_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sreg_in = sreg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUO_W - 1);
         rem_in  = VOLT_W'(dividend[PROD_W-1:QUO_W]);
         dvs_in  = divisor;
         sreg_in = dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         if (diff[VOLT_W]) begin
            rem_in  = trial[VOLT_W-1:0];
            sreg_in = {sreg_ff[QUO_W-2:0], 1'b0};
         end else begin
            rem_in  = diff[VOLT_W-1:0];
            sreg_in = {sreg_ff[QUO_W-2:0], 1'b1};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset; the datapath needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      sreg_ff <= sreg_in;
   end

   assign quotient    = sreg_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== hdl/battery_soc_lut_interpolator.sv =====
// ----------------------------------------------------------------------------
// battery_soc_lut_interpolator - battery charge lookup by linear interpolation
// Two breakpoint tables (discharge, charge) in one memory; a sequencer walks
// the selected table one entry per cycle and interpolates with a serial divide.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          content
//   req_bus  in         valid/ready        load a breakpoint or query a voltage
//   rsp_bus  out        valid/ready        percent and where_found per query
//   APB      in/out     psel/penable/...   point counts at 0x0 and 0x4
//
// A load is written when its request is accepted. A query checks the table
// ends (last point, then first), scans one segment per memory read (at most
// n-1 for n points), then multiplies and runs the serial divide when it
// interpolates, and hands the result over. The scan is paced by the single
// memory read port; the divide by the one-bit-per-cycle divider.
// Reset is synchronous; counts return to 16, table contents are not cleared.
// A result waiting on rsp_bus does not block loads; a finished query waits
// until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_soc_lut_interpolator #(
   parameter int TABLE_DEPTH = bslut_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire                            clock,
   input  wire                            reset,
   bslut_req_if.sink                      req_bus,
   bslut_rsp_if.source                    rsp_bus,
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire [bslut_pkg::CSR_AW-1:0]    paddr,
   input  wire [bslut_pkg::CSR_DW-1:0]    pwdata,
   output logic [bslut_pkg::CSR_DW-1:0]   prdata,
   output logic                           pready
);
   import bslut_pkg::*;

   localparam int IW        = $clog2(TABLE_DEPTH);
   localparam int MEM_DEPTH = 2 * TABLE_DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int ENTRY_W   = VOLT_W + PCT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_FIRST,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_RESULT
   } state_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] dis_cnt_ff;
   logic [CNT_W-1:0] chg_cnt_ff;
   logic             csr_we;

   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dis_cnt_ff <= CNT_RESET;
         chg_cnt_ff <= CNT_RESET;
      end else if (csr_we) begin
         if (paddr[2] == REG_DISCHARGE) begin
            dis_cnt_ff <= pwdata[CNT_W-1:0];
         end else begin
            chg_cnt_ff <= pwdata[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_CHARGE) begin
         prdata = {(CSR_DW-CNT_W)'(0), chg_cnt_ff};
      end else begin
         prdata = {(CSR_DW-CNT_W)'(0), dis_cnt_ff};
      end
   end

   // ------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [IW-1:0]     last_ff, last_in;
   logic [IW-1:0]     seg_ff, seg_in;
   logic [VOLT_W-1:0] q_ff, q_in;
   logic [VOLT_W-1:0] x0_ff, x0_in;
   logic [VOLT_W-1:0] x1_ff, x1_in;
   logic [PCT_W-1:0]  y0_ff, y0_in;
   logic [PCT_W-1:0]  y1_ff, y1_in;
   logic              neg_ff, neg_in;
   logic [PCT_W-1:0]  res_ff, res_in;
   where_type         code_ff, code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]  out_pct_ff, out_pct_in;
   where_type         out_code_ff, out_code_in;

   // Memory ports
   logic [ENTRY_W-1:0] mem_ff [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      req_base;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VOLT_W-1:0]  dv;
   logic [PCT_W-1:0]   dp;

   // Arithmetic for the interpolation step
   logic [VOLT_W-1:0]  dq;
   logic [PCT_W-1:0]   dy_mag;
   logic [PROD_W-1:0]  prod;
   logic [VOLT_W-1:0]  span;
   logic [QUO_W-1:0]   quo;
   logic [QUO_W-1:0]   quo_signed;
   logic [QUO_W-1:0]   sum;
   logic               div_start;
   bslut_div_status_type div_stat;

   logic              req_acc;
   logic [CNT_W-1:0]  cnt_sel;

   assign req_acc       = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_base      = req_bus.charger_connected ? AW'(TABLE_DEPTH) : '0;
   assign cnt_sel       = req_bus.charger_connected ? chg_cnt_ff : dis_cnt_ff;

   assign dv = rd_data_ff[ENTRY_W-1:PCT_W];
   assign dp = rd_data_ff[PCT_W-1:0];

   // Clamp the point count to the table and keep the last index
   always_comb begin
      int n_eff;
      n_eff = int'(cnt_sel);
      if (n_eff < 2) begin
         n_eff = 2;
      end else if (n_eff > TABLE_DEPTH) begin
         n_eff = TABLE_DEPTH;
      end
      last_in = IW'(n_eff - 1);
   end

   // Load a breakpoint into the selected table
   assign mem_we    = req_acc && (req_bus.action == ACT_LOAD)
                      && (int'(req_bus.point_index) < TABLE_DEPTH);
   assign mem_waddr = req_base + AW'(req_bus.point_index);

   // Pick the entry the next state wants to see
   always_comb begin
      case (state_ff)
         ST_IDLE:  rd_addr = req_base + AW'(last_in);
         ST_LAST:  rd_addr = base_ff;
         ST_FIRST: rd_addr = base_ff + AW'(1);
         ST_SCAN:  rd_addr = base_ff + AW'(seg_ff) + AW'(1);
         default:  rd_addr = base_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= {req_bus.point_volt, req_bus.point_percent};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Step sizes and the one multiply feeding the divider
   assign dq     = q_ff - x0_ff;
   assign span   = x1_ff - x0_ff;
   assign dy_mag = (y1_ff >= y0_ff) ? (y1_ff - y0_ff) : (y0_ff - y1_ff);
   assign prod   = PROD_W'(dq) * PROD_W'(dy_mag);
   assign div_start = (state_ff == ST_MUL);

   bslut_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (span),
      .quotient (quo),
      .status   (div_stat)
   );

   // Truncation toward zero: negate the magnitude quotient
   assign quo_signed = neg_ff ? (QUO_W'(0) - quo) : quo;
   assign sum        = QUO_W'(y0_ff) + quo_signed;

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      seg_in       = seg_ff;
      q_in         = q_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      code_in      = code_ff;
      out_pct_in   = out_pct_ff;
      out_code_in  = out_code_ff;
      rsp_valid_in = rsp_valid_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_bus.action == ACT_QUERY)) begin
               base_in  = req_base;
               q_in     = req_bus.query_volt;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (q_ff > dv) begin
               res_in   = dp;
               code_in  = WHERE_ABOVE;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (q_ff < dv) begin
               res_in   = dp;
               code_in  = WHERE_BELOW;
               state_in = ST_RESULT;
            end else begin
               x0_in    = dv;
               y0_in    = dp;
               seg_in   = IW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            x1_in = dv;
            y1_in = dp;
            if ((x0_ff <= q_ff) && (q_ff <= dv)) begin
               code_in = WHERE_INTERP;
               if (q_ff == x0_ff) begin
                  res_in   = y0_ff;
                  state_in = ST_RESULT;
               end else if (q_ff == dv) begin
                  res_in   = dp;
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_MUL;
               end
            end else if (seg_ff == last_ff) begin
               res_in   = dp;
               code_in  = WHERE_FALLBACK;
               state_in = ST_RESULT;
            end else begin
               x0_in  = dv;
               y0_in  = dp;
               seg_in = seg_ff + IW'(1);
            end
         end
         ST_MUL: begin
            neg_in   = (y1_ff < y0_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_in   = sum[PCT_W-1:0];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_pct_in   = res_ff;
               out_code_in  = code_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == ST_IDLE) begin
         last_ff <= last_in;
      end
      base_ff     <= base_in;
      seg_ff      <= seg_in;
      q_ff        <= q_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      code_ff     <= code_in;
      out_pct_ff  <= out_pct_in;
      out_code_ff <= out_code_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.percent     = out_pct_ff;
   assign rsp_bus.where_found = out_code_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // The divider finishes only while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // A query closes the request side on the next cycle
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_bus.action == ACT_QUERY)) |=> !req_bus.ready)
      else $error("request accepted while a query is in progress");

   // The scan never runs past the last point in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (seg_ff <= last_ff))
      else $error("segment scan beyond the last breakpoint");

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(out_pct_ff)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
